/* hw/rtl/pmst_pkg.sv */
package pmst_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_EDGES    = 64;
  localparam int WEIGHT_LIMIT = 10000000;

  localparam int VERTEX_W = $clog2(MAX_VERTICES);
  localparam int COUNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CFG_W    = 5;
  localparam int WEIGHT_W = 24;
  localparam int ADDR_W   = $clog2(MAX_EDGES);
  localparam int FILL_W   = $clog2(MAX_EDGES + 1);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_EDGE   = 2'd0;
  localparam logic [1:0] STATUS_SINGLE = 2'd1;
  localparam logic [1:0] STATUS_BAD    = 2'd2;
  localparam logic [1:0] STATUS_DISCON = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROUND,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } pmst_state_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    logic [WEIGHT_W-1:0] w;
  } edge_rec_t;

  typedef struct packed {
    logic       add;
    logic       clear;
    logic       latch_start;
    logic       init_build;
    logic       round_start;
    logic       scan;
    logic       commit;
    logic       emit_status;
    logic [1:0] status_code;
  } pmst_cmd_t;

  typedef struct packed {
    logic single;
    logic bad_start;
    logic fill_empty;
    logic scan_last;
    logic found;
    logic tree_done;
  } pmst_stat_t;

endpackage

/* hw/rtl/prim_minimum_spanning_tree.sv */
// add edge and clear are handled in idle; busy stays low, so they go back to back
// build: a start-vertex check, then per joined vertex one pass over the edge store
// (round start, a scan of every stored edge, a drain step and a decision)
// each result shows in the cycle after its decision, for one cycle only; no stall
// synchronous reset: vertex_count 16, edge store empty, joined flags clear;
// stored edge contents are not cleared
module prim_minimum_spanning_tree
  import pmst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // command transaction
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic [WEIGHT_W-1:0] weight,
  // vertex count register
  input  logic                vertex_count_we,
  input  logic [CFG_W-1:0]    vertex_count_wdata,
  // result transactions
  output logic                result_valid,
  output logic [VERTEX_W-1:0] edge_from,
  output logic [VERTEX_W-1:0] edge_to,
  output logic [WEIGHT_W-1:0] edge_weight,
  output logic [1:0]          status,
  output logic                last
);

  // controller drives commands, datapath reports status
  pmst_cmd_t  ctl;
  pmst_stat_t stat;

  // sequencer: idle, start-vertex check, then per round a full edge sweep
  // followed by a decision that either joins the best vertex or flags
  // a disconnected graph
  pmst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // edge store, joined flags, join ranks and the running best edge;
  // one sweep per round compares weight first, then the join rank of the
  // joined endpoint, and keeps the earlier edge on a full tie
  pmst_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .vertex_a           (vertex_a),
    .vertex_b           (vertex_b),
    .weight             (weight),
    .vertex_count_we    (vertex_count_we),
    .vertex_count_wdata (vertex_count_wdata),
    .result_valid       (result_valid),
    .edge_from          (edge_from),
    .edge_to            (edge_to),
    .edge_weight        (edge_weight),
    .status             (status),
    .last               (last)
  );

endmodule

/* hw/rtl/pmst_ctrl.sv */
module pmst_ctrl
  import pmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  pmst_stat_t stat,
  output pmst_cmd_t  ctl,
  output logic       busy
);

  pmst_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    ctl             = '0;
    ctl.status_code = STATUS_EDGE;
    busy            = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (cmd)
            CMD_ADD: begin
              ctl.add = 1'b1;
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            CMD_BUILD: begin
              ctl.latch_start = 1'b1;
              state_next      = ST_CHECK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        priority if (stat.single) begin
          ctl.emit_status = 1'b1;
          ctl.status_code = STATUS_SINGLE;
          state_next      = ST_IDLE;
        end else if (stat.bad_start) begin
          ctl.emit_status = 1'b1;
          ctl.status_code = STATUS_BAD;
          state_next      = ST_IDLE;
        end else begin
          ctl.init_build = 1'b1;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round_start = 1'b1;
        if (stat.fill_empty) begin
          ctl.emit_status = 1'b1;
          ctl.status_code = STATUS_DISCON;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.found) begin
          ctl.emit_status = 1'b1;
          ctl.status_code = STATUS_DISCON;
          state_next      = ST_IDLE;
        end else begin
          ctl.commit = 1'b1;
          state_next = stat.tree_done ? ST_IDLE : ST_ROUND;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/pmst_datapath.sv */
module pmst_datapath
  import pmst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  pmst_cmd_t           ctl,
  output pmst_stat_t          stat,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic                vertex_count_we,
  input  logic [CFG_W-1:0]    vertex_count_wdata,
  output logic                result_valid,
  output logic [VERTEX_W-1:0] edge_from,
  output logic [VERTEX_W-1:0] edge_to,
  output logic [WEIGHT_W-1:0] edge_weight,
  output logic [1:0]          status,
  output logic                last
);

  logic [CFG_W-1:0]        vertex_count;
  logic [COUNT_W-1:0]      n_active;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_m1;
  logic                    add_ok;
  edge_rec_t               store [MAX_EDGES];
  edge_rec_t               rd_data;
  logic                    rd_valid;
  logic [ADDR_W-1:0]       scan_idx;
  logic [VERTEX_W-1:0]     start_v;
  logic [MAX_VERTICES-1:0] joined;
  logic [VERTEX_W-1:0]     join_rank [MAX_VERTICES];
  logic [COUNT_W-1:0]      total;

  logic                    found;
  logic [VERTEX_W-1:0]     best_from;
  logic [VERTEX_W-1:0]     best_to;
  logic [WEIGHT_W-1:0]     best_w;
  logic [VERTEX_W-1:0]     best_rank;

  logic                    ja, jb, cand, other_ok, better, take;
  logic [VERTEX_W-1:0]     v_sel, other_sel, rank_v;

  // clamp the configured count to one..MAX_VERTICES
  always_comb begin
    priority if (vertex_count == '0) begin
      n_active = COUNT_W'(1);
    end else if (COUNT_W'(vertex_count) > COUNT_W'(MAX_VERTICES)) begin
      n_active = COUNT_W'(MAX_VERTICES);
    end else begin
      n_active = COUNT_W'(vertex_count);
    end
  end

  assign add_ok = (COUNT_W'(vertex_a) < n_active) && (COUNT_W'(vertex_b) < n_active)
                  && (weight != '0) && (weight < WEIGHT_W'(WEIGHT_LIMIT))
                  && (fill < FILL_W'(MAX_EDGES));

  assign fill_m1 = fill - FILL_W'(1);

  assign stat.single     = (n_active == COUNT_W'(1));
  assign stat.bad_start  = (COUNT_W'(start_v) >= n_active);
  assign stat.fill_empty = (fill == '0);
  assign stat.scan_last  = (FILL_W'(scan_idx) == fill_m1);
  assign stat.found      = found;
  assign stat.tree_done  = ((total + COUNT_W'(1)) == n_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_W'(MAX_VERTICES);
      fill         <= '0;
    end else begin
      if (vertex_count_we) begin
        vertex_count <= vertex_count_wdata;
      end
      if (ctl.clear) begin
        fill <= '0;
      end else if (ctl.add && add_ok) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // edge store
  always_ff @(posedge clk) begin
    if (ctl.add && add_ok) begin
      store[fill[ADDR_W-1:0]] <= '{a: vertex_a, b: vertex_b, w: weight};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      rd_data <= store[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctl.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.round_start) begin
      scan_idx <= '0;
    end else if (ctl.scan) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
  end

  // candidate: exactly one endpoint joined, other endpoint in range
  always_comb begin
    ja        = joined[rd_data.a];
    jb        = joined[rd_data.b];
    cand      = ja ^ jb;
    v_sel     = ja ? rd_data.a : rd_data.b;
    other_sel = ja ? rd_data.b : rd_data.a;
    other_ok  = COUNT_W'(other_sel) < n_active;
    rank_v    = join_rank[v_sel];
    better    = !found || (rd_data.w < best_w)
                || ((rd_data.w == best_w) && (rank_v < best_rank));
    take      = rd_valid && cand && other_ok && better;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_start) begin
      start_v <= vertex_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found  <= 1'b0;
      joined <= '0;
      total  <= '0;
    end else begin
      if (ctl.round_start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (ctl.init_build) begin
        joined <= MAX_VERTICES'(1) << start_v;
        total  <= COUNT_W'(1);
      end else if (ctl.commit) begin
        joined[best_to] <= 1'b1;
        total           <= total + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init_build) begin
      join_rank[start_v] <= '0;
    end else if (ctl.commit) begin
      join_rank[best_to] <= total[VERTEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_from <= v_sel;
      best_to   <= other_sel;
      best_w    <= rd_data.w;
      best_rank <= rank_v;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit_status || ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_status) begin
      edge_from   <= '0;
      edge_to     <= '0;
      edge_weight <= '0;
      status      <= ctl.status_code;
      last        <= 1'b1;
    end else if (ctl.commit) begin
      edge_from   <= best_from;
      edge_to     <= best_to;
      edge_weight <= best_w;
      status      <= STATUS_EDGE;
      last        <= stat.tree_done;
    end
  end

endmodule
